>>> sv/hufw_pkg.sv
// shared types and constants for the huffman table walk decoder
package hufw_pkg;

  localparam int unsigned NODE_W    = 16;
  localparam int unsigned SYM_W     = 15;
  localparam int unsigned LOAD_IX_W = 13;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RAW_IX_W  = 15;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned LEAF_BIT  = 15;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [LOAD_IX_W-1:0] table_index;
    logic [NODE_W-1:0]    table_word;
    logic [BYTE_W-1:0]    code_byte;
    logic                 block_last;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             block_done;
    logic             fault;
  } out_beat_t;

  // request to the index unit: current node plus the bit being consumed
  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] node;
    logic              bit_one;
  } idx_req_t;

endpackage

>>> sv/hufw_table_mem.sv
// tree table memory, one write port and one registered read port
module hufw_table_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [hufw_pkg::NODE_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [hufw_pkg::NODE_W-1:0] rd_data_o
);

  logic [hufw_pkg::NODE_W-1:0] mem [DEPTH];
  logic [hufw_pkg::NODE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/hufw_index_unit.sv
// shared child index unit: offset add, then reduction of the word index modulo the depth
module hufw_index_unit #(
  parameter int unsigned TABLE_WORDS = 8192,
  parameter int unsigned AW          = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hufw_pkg::idx_req_t req_i,
  output logic               done_o,
  output logic [AW-1:0]      idx_o
);

  localparam bit          IS_POW2 = ((TABLE_WORDS & (TABLE_WORDS - 1)) == 0);
  // reciprocal scaled by 2^30, quotient estimate is at most one low
  localparam logic [30:0] RECIP   = 31'((64'd1 << 30) / 64'(TABLE_WORDS));
  localparam logic [16:0] DEPTH17 = 17'(TABLE_WORDS);

  logic [hufw_pkg::NODE_W-1:0]   offset;
  logic [hufw_pkg::RAW_IX_W-1:0] raw_ix;
  logic [45:0]                   prod;
  logic [31:0]                   q_times_d;
  logic [31:0]                   rem_wide;
  logic [16:0]                   reduced;

  logic                          v1_q, v2_q, v3_q;
  logic [hufw_pkg::RAW_IX_W-1:0] x1_q, x2_q;
  logic [hufw_pkg::RAW_IX_W-1:0] quot_q;
  logic [16:0]                   rem_q;

  // byte offset wraps at 16 bits, odd low bit dropped
  assign offset = req_i.node + (req_i.bit_one ? 16'd2 : 16'd0);
  assign raw_ix = offset[hufw_pkg::NODE_W-1:1];

  assign prod      = 46'(x1_q) * 46'(RECIP);
  assign q_times_d = 32'(quot_q) * 32'(TABLE_WORDS);
  assign rem_wide  = 32'(x2_q) - q_times_d;
  assign reduced   = (rem_q >= DEPTH17) ? (rem_q - DEPTH17) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= raw_ix;
    x2_q   <= x1_q;
    quot_q <= prod[44:30];
    rem_q  <= rem_wide[16:0];
  end

  // power-of-two depth is a plain mask
  assign done_o = IS_POW2 ? v1_q : v3_q;
  assign idx_o  = IS_POW2 ? x1_q[AW-1:0] : reduced[AW-1:0];

endmodule

>>> sv/huffman_table_walk_decoder.sv
// top level: huffman tree table walk decoder with sequencer and result staging
// load beat: written in the cycle it is accepted, ready again the next cycle
// byte beat: each bit waits on the index unit (longer when TABLE_WORDS is not a power of two)
//   and the dependent table read; each symbol starts with a root read, each result is staged
//   and the byte closes through the next or flush state; output stalls keep the block busy
// reset: asynchronous, active low; walk restarts at the root, table contents undefined
module huffman_table_walk_decoder #(
  parameter int unsigned TABLE_WORDS = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hufw_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hufw_pkg::out_beat_t  out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEXT,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_BIT_GO,
    ST_IDX_WAIT,
    ST_NODE_CHK,
    ST_PUSH,
    ST_FLUSH
  } state_e;

  state_e                         state_q;
  logic [hufw_pkg::BYTE_W-1:0]    byte_q;
  logic                           last_q;
  logic [hufw_pkg::CNT_W-1:0]     cnt_q;
  logic [hufw_pkg::NODE_W-1:0]    node_q;
  logic                           start_q;   // next bit begins a new symbol
  logic                           end_q;     // block ends after the pending push
  hufw_pkg::out_beat_t            new_q;     // freshly produced result
  hufw_pkg::out_beat_t            pend_q;    // held back until we know if it is the last
  logic                           pend_vld_q;
  hufw_pkg::out_beat_t            out_q;
  logic                           out_vld_q;

  logic                           accept;
  logic                           slot_free;
  logic                           out_load;
  logic                           wr_en;
  logic [hufw_pkg::RAW_IX_W-1:0]  wr_ix_wide;
  logic [AW-1:0]                  rd_addr;
  logic [hufw_pkg::NODE_W-1:0]    rd_word;
  logic                           rd_leaf;
  hufw_pkg::idx_req_t             idx_req;
  logic                           idx_done;
  logic [AW-1:0]                  idx;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_vld_q || out_ready_i;
  // pending result moves into the output register this cycle
  assign out_load    = ((state_q == ST_PUSH) || (state_q == ST_FLUSH)) &&
                       pend_vld_q && slot_free;

  // table load, writes beyond the table depth are dropped
  assign wr_ix_wide = hufw_pkg::RAW_IX_W'(in_data_i.table_index);
  assign wr_en      = accept && (in_data_i.cmd == hufw_pkg::CMD_LOAD) &&
                      (32'(in_data_i.table_index) < 32'(TABLE_WORDS));

  // root lives at word 0, children come from the index unit
  assign rd_addr = (state_q == ST_ROOT_RD) ? '0 : idx;
  assign rd_leaf = rd_word[hufw_pkg::LEAF_BIT];

  assign idx_req.start   = (state_q == ST_BIT_GO);
  assign idx_req.node    = node_q;
  assign idx_req.bit_one = byte_q[hufw_pkg::BYTE_W-1];

  hufw_table_mem #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_ix_wide[AW-1:0]),
    .wr_data_i (in_data_i.table_word),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  hufw_index_unit #(
    .TABLE_WORDS (TABLE_WORDS),
    .AW          (AW)
  ) u_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (idx_req),
    .done_o (idx_done),
    .idx_o  (idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      byte_q     <= '0;
      last_q     <= 1'b0;
      cnt_q      <= '0;
      node_q     <= '0;
      start_q    <= 1'b1;
      end_q      <= 1'b0;
      new_q      <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      // output beat taken and nothing loaded behind it
      if (out_vld_q && out_ready_i && !out_load) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (in_data_i.cmd == hufw_pkg::CMD_BYTE)) begin
            byte_q  <= in_data_i.code_byte;
            last_q  <= in_data_i.block_last;
            cnt_q   <= '0;
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (cnt_q == hufw_pkg::BITS_PER_BYTE) begin
            if (last_q) begin
              // final byte ran out without a symbol: truncated block
              new_q   <= '{symbol: '0, run_last: 1'b0, block_done: 1'b1, fault: 1'b1};
              end_q   <= 1'b1;
              start_q <= 1'b1;
              node_q  <= '0;
              state_q <= ST_PUSH;
            end else begin
              state_q <= ST_FLUSH;
            end
          end else if (start_q) begin
            state_q <= ST_ROOT_RD;
          end else begin
            state_q <= ST_BIT_GO;
          end
        end
        ST_ROOT_RD: begin
          state_q <= ST_ROOT_CHK;
        end
        ST_ROOT_CHK: begin
          if (rd_leaf) begin
            // leaf at the root: fault, rest of the byte dropped
            new_q   <= '{symbol: '0, run_last: 1'b0, block_done: 1'b1, fault: 1'b1};
            end_q   <= 1'b1;
            node_q  <= '0;
            state_q <= ST_PUSH;
          end else begin
            node_q  <= rd_word;
            start_q <= 1'b0;
            state_q <= ST_BIT_GO;
          end
        end
        ST_BIT_GO: begin
          byte_q  <= byte_q << 1;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_IDX_WAIT;
        end
        ST_IDX_WAIT: begin
          if (idx_done) begin
            state_q <= ST_NODE_CHK;
          end
        end
        ST_NODE_CHK: begin
          if (rd_leaf) begin
            new_q   <= '{symbol: rd_word[hufw_pkg::SYM_W-1:0], run_last: 1'b0,
                         block_done: last_q, fault: 1'b0};
            end_q   <= last_q;
            start_q <= 1'b1;
            node_q  <= '0;
            state_q <= ST_PUSH;
          end else begin
            node_q  <= rd_word;
            state_q <= ST_NEXT;
          end
        end
        ST_PUSH: begin
          // earlier pending result is known not to be the last, send it on
          if (!pend_vld_q) begin
            pend_q     <= new_q;
            pend_vld_q <= 1'b1;
            state_q    <= end_q ? ST_FLUSH : ST_NEXT;
          end else if (slot_free) begin
            out_q     <= pend_q;
            out_vld_q <= 1'b1;
            pend_q    <= new_q;
            state_q   <= end_q ? ST_FLUSH : ST_NEXT;
          end
        end
        ST_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            out_q      <= '{symbol: pend_q.symbol, run_last: 1'b1,
                            block_done: pend_q.block_done, fault: pend_q.fault};
            out_vld_q  <= 1'b1;
            pend_vld_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/hufw_checker.sv
// port-level checker for the huffman table walk decoder, bound to the top level
module hufw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input hufw_pkg::in_beat_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hufw_pkg::out_beat_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a byte beat keeps the block busy for at least the next cycle
  a_byte_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd == hufw_pkg::CMD_BYTE) |=> !in_ready_o)
    else $error("ready right after a byte beat");

  // a table load leaves the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.cmd == hufw_pkg::CMD_LOAD) |=> in_ready_o)
    else $error("not ready after a table load");

  // a fault carries symbol zero and ends the block
  a_fault_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fault |->
      (out_data_o.symbol == '0) && out_data_o.block_done)
    else $error("malformed fault result");

  // nothing follows the result that ends a block within the same byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.block_done |-> out_data_o.run_last)
    else $error("block end without run end");

endmodule

bind huffman_table_walk_decoder hufw_checker u_hufw_checker (.*);
